### rtl/core/fwpi_pkg.sv
// ----------------------------------------------------------------------------
// fwpi_pkg
// shared constants, codes and types of the queue with positional insert
// ----------------------------------------------------------------------------
package fwpi_pkg;

  localparam int DEPTH       = 16;
  localparam int KEY_W       = 32;
  localparam int OP_W        = 2;
  localparam int POS_W       = 4;
  localparam int ENTRY_CNT_W = 5;
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int IDX_W       = $clog2(DEPTH);
  localparam int CMP_W       = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 40;

  // request operation codes
  localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_INSERT = 2'd2;

  // per-cell actions broadcast along the chain
  localparam logic [1:0] ACT_HOLD     = 2'd0;
  localparam logic [1:0] ACT_LOAD_AT  = 2'd1;
  localparam logic [1:0] ACT_SHIFT_FW = 2'd2;
  localparam logic [1:0] ACT_OPEN_GAP = 2'd3;

  typedef struct packed {
    logic [1:0]       act;
    logic [IDX_W-1:0] sel;
    logic [KEY_W-1:0] key;
  } cell_ctl_t;

  typedef struct packed {
    logic               dropped;
    logic [ENTRY_CNT_W-1:0] entry_count;
    logic               head_valid;
    logic [KEY_W-1:0]   head_key;
  } result_t;

endpackage

### rtl/core/fifo_with_positional_insert_top.sv
// ----------------------------------------------------------------------------
// fifo_with_positional_insert_top
// ordered key queue with append, remove-head and insert-after-position
// ----------------------------------------------------------------------------
//  channel | dir | tdata fields (lsb first)
//  in_     | in  | operation[1:0], key[33:2], position[37:34], zero pad
//  out_    | out | head_key[31:0], head_valid[32], entry_count[37:33],
//          |     | dropped[38], zero pad
//
//  one request is taken per cycle while in_tready is high; every slot of the
//  cell chain updates in the same cycle; the result is registered in the buffer
//  a two-entry result buffer lets requests flow while the output stalls;
//  in_tready falls only when both entries wait
//  rst_n (synchronous) empties the queue and the result buffer
// ----------------------------------------------------------------------------
module fifo_with_positional_insert_top
  import fwpi_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // operation, key, position
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata   // head_key, head_valid, entry_count, dropped
);

  logic [OP_W-1:0]  op;
  logic [KEY_W-1:0] req_key;
  logic [POS_W-1:0] pos;

  assign op      = in_tdata[OP_W-1:0];
  assign req_key = in_tdata[OP_W+KEY_W-1:OP_W];
  assign pos     = in_tdata[OP_W+KEY_W+POS_W-1:OP_W+KEY_W];

  logic             in_fire;
  logic             out_fire;
  logic [CNT_W-1:0] occ_r;
  logic [CNT_W-1:0] occ_nxt;
  logic             done;
  cell_ctl_t        ctl;
  logic [KEY_W-1:0] cell_key [DEPTH];
  logic [KEY_W-1:0] head_nxt;
  logic             full;
  logic             empty;
  logic             pos_ok;

  assign in_fire  = in_tvalid && in_tready;
  assign out_fire = out_tvalid && out_tready;
  assign full     = (occ_r == CNT_W'(DEPTH));
  assign empty    = (occ_r == '0);
  assign pos_ok   = (CMP_W'(pos) < CMP_W'(occ_r));

  always_comb begin
    done     = 1'b0;
    ctl.act  = ACT_HOLD;
    ctl.sel  = '0;
    ctl.key  = req_key;
    occ_nxt  = occ_r;
    head_nxt = cell_key[0];
    if (in_fire) begin
      case (op)
        OP_APPEND: begin
          if (!full) begin
            done    = 1'b1;
            ctl.act = ACT_LOAD_AT;
            ctl.sel = occ_r[IDX_W-1:0];
            occ_nxt = occ_r + CNT_W'(1);
            if (empty) head_nxt = req_key;
          end
        end
        OP_REMOVE: begin
          if (!empty) begin
            done     = 1'b1;
            ctl.act  = ACT_SHIFT_FW;
            occ_nxt  = occ_r - CNT_W'(1);
            head_nxt = cell_key[1];
          end
        end
        OP_INSERT: begin
          if (!full && pos_ok) begin
            done    = 1'b1;
            ctl.act = ACT_OPEN_GAP;
            ctl.sel = IDX_W'(CMP_W'(pos) + CMP_W'(1));
            occ_nxt = occ_r + CNT_W'(1);
          end
        end
        default: done = 1'b0;
      endcase
    end
  end

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      logic [KEY_W-1:0] left_k;
      logic [KEY_W-1:0] right_k;
      if (g == 0) begin : g_first
        assign left_k = '0;
      end else begin : g_mid_l
        assign left_k = cell_key[g-1];
      end
      if (g == DEPTH - 1) begin : g_last
        assign right_k = '0;
      end else begin : g_mid_r
        assign right_k = cell_key[g+1];
      end
      fwpi_cell u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .idx       (IDX_W'(g)),
        .left_key  (left_k),
        .right_key (right_k),
        .key       (cell_key[g])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  // result record for this request
  result_t res;
  always_comb begin
    res.head_valid  = (occ_nxt != '0);
    res.head_key    = res.head_valid ? head_nxt : '0;
    res.entry_count = ENTRY_CNT_W'(occ_nxt);
    res.dropped     = !done;
  end

  // two-entry result buffer: slot 0 drives the port, slot 1 catches a stall
  result_t    buf0_r;
  result_t    buf0_nxt;
  result_t    buf1_r;
  result_t    buf1_nxt;
  logic [1:0] bcnt_r;
  logic [1:0] bcnt_nxt;

  always_comb begin
    buf0_nxt = buf0_r;
    buf1_nxt = buf1_r;
    bcnt_nxt = bcnt_r;
    if (out_fire) begin
      buf0_nxt = buf1_r;
      bcnt_nxt = bcnt_nxt - 2'd1;
    end
    if (in_fire) begin
      if (bcnt_nxt == 2'd0) begin
        buf0_nxt = res;
      end else begin
        buf1_nxt = res;
      end
      bcnt_nxt = bcnt_nxt + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    buf0_r <= buf0_nxt;
    buf1_r <= buf1_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bcnt_r <= '0;
    end else begin
      bcnt_r <= bcnt_nxt;
    end
  end

  assign in_tready  = (bcnt_r != 2'd2);
  assign out_tvalid = (bcnt_r != 2'd0);
  assign out_tdata  = {{(OUT_DATA_W - $bits(result_t)){1'b0}}, buf0_r};

endmodule

### rtl/core/fwpi_cell.sv
// ----------------------------------------------------------------------------
// fwpi_cell
// one queue slot: holds a key and takes it from a neighbour or the request
// ----------------------------------------------------------------------------
module fwpi_cell
  import fwpi_pkg::*;
(
  input  logic             clk,
  input  cell_ctl_t        ctl,
  input  logic [IDX_W-1:0] idx,
  input  logic [KEY_W-1:0] left_key,
  input  logic [KEY_W-1:0] right_key,
  output logic [KEY_W-1:0] key
);

  logic [KEY_W-1:0] key_r;
  logic [KEY_W-1:0] key_nxt;

  always_comb begin
    key_nxt = key_r;
    case (ctl.act)
      ACT_HOLD: begin
        key_nxt = key_r;
      end
      ACT_LOAD_AT: begin
        if (idx == ctl.sel) key_nxt = ctl.key;
      end
      ACT_SHIFT_FW: begin
        key_nxt = right_key;
      end
      ACT_OPEN_GAP: begin
        // slots past the gap take their left neighbour
        if (idx == ctl.sel) begin
          key_nxt = ctl.key;
        end else if (idx > ctl.sel) begin
          key_nxt = left_key;
        end
      end
      default: key_nxt = key_r;
    endcase
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

  assign key = key_r;

endmodule

### rtl/core/fwpi_checker.sv
// ----------------------------------------------------------------------------
// fwpi_checker
// port-level checks on the queue with positional insert
// ----------------------------------------------------------------------------
module fwpi_checker
  import fwpi_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  logic [KEY_W-1:0]       o_head;
  logic                   o_hv;
  logic [ENTRY_CNT_W-1:0] o_cnt;

  assign o_head = out_tdata[KEY_W-1:0];
  assign o_hv   = out_tdata[KEY_W];
  assign o_cnt  = out_tdata[KEY_W+ENTRY_CNT_W:KEY_W+1];

  // after every accepted request, out_tvalid is high on the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("no result after accepted request");

  a_head_valid_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (o_hv == (o_cnt != '0)))
    else $error("head_valid disagrees with entry_count");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (o_cnt <= ENTRY_CNT_W'(DEPTH)))
    else $error("entry_count above depth");

  a_empty_head_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !o_hv |-> (o_head == '0))
    else $error("empty queue shows a head key");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

endmodule

bind fifo_with_positional_insert_top fwpi_checker u_fwpi_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
